FILE: src/lrubd_pkg.sv
// Shared types and constants for the LRU block buffer directory.
package lrubd_pkg;

  // Field widths.
  localparam int TAG_W    = 31;
  localparam int OP_W     = 2;
  localparam int LIMIT_W  = 5;
  localparam int WB_CNT_W = 5;

  // Default number of cells in the recency chain.
  localparam int ENTRIES_DEFAULT = 16;

  // Reset value of the active limit register.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // Most writebacks that one flush may emit.
  localparam logic [WB_CNT_W-1:0] RESULT_CAP = 5'd16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  // One directory entry as held in a cell.
  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Controls broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp;  // capture tag compare against the incoming offset
    logic upd;  // apply the access update (shift toward the tail)
    logic hit;  // the access update is for a hit
    logic rot;  // rotate the ring by one cell toward the head
  } chain_ctl_t;

endpackage

FILE: src/lrubd_cell.sv
// One cell of the recency chain: holds the entry at one recency position.
module lrubd_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  lrubd_pkg::chain_ctl_t      ctl,
  input  logic                       shift_en,
  input  logic [lrubd_pkg::TAG_W-1:0] cmp_ofs,
  input  lrubd_pkg::entry_t          from_prev,
  input  lrubd_pkg::entry_t          from_next,
  output lrubd_pkg::entry_t          entry,
  output logic                       match
);

  logic                        valid;
  logic                        dirty;
  logic [lrubd_pkg::TAG_W-1:0] tag;

  assign entry = '{valid: valid, dirty: dirty, tag: tag};

  // Status bits take the neighbor's entry on a rotate or an update shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dirty <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctl.rot) begin
        valid <= from_next.valid;
        dirty <= from_next.dirty;
      end else if (ctl.upd && shift_en) begin
        valid <= from_prev.valid;
        dirty <= from_prev.dirty;
      end
      if (ctl.cmp) begin
        match <= valid && (tag == cmp_ofs);
      end
    end
  end

  // The tag follows the same moves and needs no reset.
  always_ff @(posedge clk) begin
    if (ctl.rot) begin
      tag <= from_next.tag;
    end else if (ctl.upd && shift_en) begin
      tag <= from_prev.tag;
    end
  end

endmodule

FILE: src/lrubd_chain.sv
// Row of cells ordered by recency, with the hit and victim reductions.
module lrubd_chain #(
  parameter int ENTRIES = lrubd_pkg::ENTRIES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lrubd_pkg::chain_ctl_t               ctl,
  input  logic [lrubd_pkg::TAG_W-1:0]         cmp_ofs,
  input  lrubd_pkg::entry_t                   new_entry,
  input  lrubd_pkg::entry_t                   head_clean,
  input  logic [$clog2(ENTRIES+1)-1:0]        shift_lim,
  output logic                                hit,
  output logic                                hit_dirty,
  output lrubd_pkg::entry_t                   head,
  output lrubd_pkg::entry_t                   victim
);

  localparam int CW = $clog2(ENTRIES + 1);

  lrubd_pkg::entry_t cells [ENTRIES];
  logic [ENTRIES-1:0] match_v;
  logic [ENTRIES-1:0] dirty_v;
  logic [ENTRIES-1:0] tail_v;

  genvar k;
  generate
    for (k = 0; k < ENTRIES; k++) begin : g_cell
      logic              shift_en;
      logic [CW-1:0]     kpos;
      lrubd_pkg::entry_t prev_e;
      lrubd_pkg::entry_t next_e;

      assign kpos = CW'(k);

      // On a hit every cell up to the hit position shifts; on a miss the
      // shift reaches the first free cell, or the tail when evicting.
      assign shift_en = ctl.hit ? (|match_v[ENTRIES-1:k]) : (kpos < shift_lim);

      if (k == 0) begin : g_first
        assign prev_e = new_entry;
      end else begin : g_mid_prev
        assign prev_e = cells[k-1];
      end

      // The last cell closes the ring with the head entry, cleaned if written back.
      if (k == ENTRIES - 1) begin : g_last
        assign next_e    = head_clean;
        assign tail_v[k] = cells[k].valid;
      end else begin : g_mid_next
        assign next_e    = cells[k+1];
        assign tail_v[k] = cells[k].valid && !cells[k+1].valid;
      end

      assign dirty_v[k] = cells[k].dirty;

      lrubd_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .shift_en  (shift_en),
        .cmp_ofs   (cmp_ofs),
        .from_prev (prev_e),
        .from_next (next_e),
        .entry     (cells[k]),
        .match     (match_v[k])
      );
    end
  endgenerate

  assign hit       = |match_v;
  assign hit_dirty = |(match_v & dirty_v);
  assign head      = cells[0];

  // The least recent entry is the last valid cell; select it one-hot.
  always_comb begin
    victim = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      victim.valid = victim.valid | tail_v[i];
      victim.dirty = victim.dirty | (tail_v[i] & cells[i].dirty);
      victim.tag   = victim.tag | ({lrubd_pkg::TAG_W{tail_v[i]}} & cells[i].tag);
    end
  end

endmodule

FILE: src/lru_block_buffer_directory.sv
// Top level of the LRU block buffer directory: control, output register, cell chain.
// An access result beat is registered: the tag compare is captured when the beat is accepted,
// then the chain shift loads the output register once it is free. The input stays closed
// until that shift is done. A flush rotates the ring once, then emits a final beat; output stalls hold its steps.
// Reset (synchronous, active high) empties the directory and sets the limit to 16.
// No clearing pass follows reset; the block accepts beats in the next cycle.
module lru_block_buffer_directory #(
  parameter int ENTRIES = lrubd_pkg::ENTRIES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [lrubd_pkg::LIMIT_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lrubd_pkg::OP_W-1:0]    opcode,
  input  logic [lrubd_pkg::TAG_W-1:0]   block_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic                          fetch_valid,
  output logic                          writeback_valid,
  output logic [lrubd_pkg::TAG_W-1:0]   writeback_offset,
  output logic                          last
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES);
  localparam int LW = (CW > lrubd_pkg::LIMIT_W) ? CW : lrubd_pkg::LIMIT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_UPD   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_FEND  = 2'd3;

  logic [1:0]                        state;
  logic [CW-1:0]                     used_count;
  logic [lrubd_pkg::LIMIT_W-1:0]     active_limit;
  logic [IW-1:0]                     step_cnt;
  logic [lrubd_pkg::WB_CNT_W-1:0]    wb_cnt;
  logic                              held_valid;
  logic [lrubd_pkg::TAG_W-1:0]       held_tag;
  logic [lrubd_pkg::OP_W-1:0]        op_q;
  logic [lrubd_pkg::TAG_W-1:0]       ofs_q;

  lrubd_pkg::chain_ctl_t ctl;
  lrubd_pkg::entry_t     new_entry;
  lrubd_pkg::entry_t     head_clean;
  lrubd_pkg::entry_t     head;
  lrubd_pkg::entry_t     victim;
  logic                  chain_hit;
  logic                  hit_dirty;
  logic [CW-1:0]         shift_lim;

  logic          out_free;
  logic          accept;
  logic          do_upd;
  logic          do_step;
  logic          do_fin;
  logic          take;
  logic          is_write;
  logic          evict;
  logic [LW-1:0] lim_ext;
  logic [LW-1:0] eff_limit;
  logic [LW-1:0] cnt_ext;

  logic                          push;
  logic                          hit_n;
  logic                          fetch_n;
  logic                          wbv_n;
  logic [lrubd_pkg::TAG_W-1:0]   wbo_n;
  logic                          last_n;

  // Handshake and step qualifiers.
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign do_upd   = out_free && (state == S_UPD);
  assign do_step  = out_free && (state == S_FLUSH);
  assign do_fin   = out_free && (state == S_FEND);
  assign is_write = (op_q == lrubd_pkg::OP_WRITE);

  // Effective limit: zero acts as one, anything above the cell count as the cell count.
  assign lim_ext = LW'(active_limit);
  assign cnt_ext = LW'(used_count);
  always_comb begin
    if (lim_ext == '0) begin
      eff_limit = LW'(1);
    end else if (lim_ext > LW'(ENTRIES)) begin
      eff_limit = LW'(ENTRIES);
    end else begin
      eff_limit = lim_ext;
    end
  end
  assign evict = (cnt_ext != '0) && (cnt_ext >= eff_limit);

  // Miss shift region ends at the tail when evicting, else one past it.
  assign shift_lim = evict ? used_count : used_count + CW'(1);

  // Entry placed at the head by an access.
  assign new_entry = '{valid: 1'b1,
                       dirty: chain_hit ? (hit_dirty || is_write) : is_write,
                       tag:   ofs_q};

  // During a flush the head is written back if dirty and the cap allows.
  assign take       = head.valid && head.dirty && (wb_cnt < lrubd_pkg::RESULT_CAP);
  assign head_clean = '{valid: head.valid, dirty: head.dirty && !take, tag: head.tag};

  assign ctl = '{cmp: accept, upd: do_upd, hit: chain_hit, rot: do_step};

  lrubd_chain #(
    .ENTRIES (ENTRIES)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cmp_ofs    (block_offset),
    .new_entry  (new_entry),
    .head_clean (head_clean),
    .shift_lim  (shift_lim),
    .hit        (chain_hit),
    .hit_dirty  (hit_dirty),
    .head       (head),
    .victim     (victim)
  );

  // Result beat selection. A flush writeback is held back one step so that
  // the final one can carry last.
  always_comb begin
    push    = do_upd || do_fin || (do_step && take && held_valid);
    hit_n   = 1'b0;
    fetch_n = 1'b0;
    wbv_n   = 1'b0;
    wbo_n   = '0;
    last_n  = 1'b0;
    priority if (do_upd) begin
      hit_n   = chain_hit;
      fetch_n = !chain_hit;
      wbv_n   = !chain_hit && evict && victim.dirty;
      wbo_n   = (!chain_hit && evict && victim.dirty) ? victim.tag : '0;
      last_n  = 1'b1;
    end else if (do_fin) begin
      wbv_n   = held_valid;
      wbo_n   = held_valid ? held_tag : '0;
      last_n  = 1'b1;
    end else begin
      wbv_n   = 1'b1;
      wbo_n   = held_tag;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      used_count   <= '0;
      active_limit <= lrubd_pkg::LIMIT_RESET;
      step_cnt     <= '0;
      wb_cnt       <= '0;
      held_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        active_limit <= cfg_data;
      end

      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (opcode)
              lrubd_pkg::OP_READ,
              lrubd_pkg::OP_WRITE: begin
                state <= S_UPD;
              end
              lrubd_pkg::OP_FLUSH: begin
                state      <= S_FLUSH;
                step_cnt   <= '0;
                wb_cnt     <= '0;
                held_valid <= 1'b0;
              end
              lrubd_pkg::OP_NONE: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_UPD: begin
          if (do_upd) begin
            state <= S_IDLE;
            if (!chain_hit && !evict) begin
              used_count <= used_count + CW'(1);
            end
          end
        end
        S_FLUSH: begin
          if (do_step) begin
            step_cnt <= step_cnt + IW'(1);
            if (take) begin
              held_valid <= 1'b1;
              wb_cnt     <= wb_cnt + lrubd_pkg::WB_CNT_W'(1);
            end
            if (step_cnt == IW'(ENTRIES - 1)) begin
              state <= S_FEND;
            end
          end
        end
        S_FEND: begin
          if (do_fin) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= opcode;
      ofs_q <= block_offset;
    end
    if (do_step && take) begin
      held_tag <= head.tag;
    end
    if (push) begin
      hit              <= hit_n;
      fetch_valid      <= fetch_n;
      writeback_valid  <= wbv_n;
      writeback_offset <= wbo_n;
      last             <= last_n;
    end
  end

endmodule

FILE: src/lrubd_checker.sv
// Port-level checks for the LRU block buffer directory and their binding.
module lrubd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [lrubd_pkg::OP_W-1:0]    opcode,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          hit,
  input logic                          fetch_valid,
  input logic                          writeback_valid,
  input logic [lrubd_pkg::TAG_W-1:0]   writeback_offset,
  input logic                          last
);

  // A stalled result beat stays and holds its writeback offset and last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(writeback_offset) && $stable(last))
    else $error("result beat dropped or changed while stalled");

  // Any accepted beat other than a no-op keeps the input closed in the next cycle.
  a_busy_after_access: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (opcode != lrubd_pkg::OP_NONE) |=> !in_ready)
    else $error("input reopened right after accepting an item");

  // A hit neither fetches nor writes back, and ends its item.
  a_hit_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !fetch_valid && !writeback_valid && last)
    else $error("hit result carries a fetch or writeback");

  // A fetch belongs to a miss, which gives exactly one beat.
  a_fetch_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && fetch_valid |-> !hit && last)
    else $error("fetch result malformed");

  // No writeback means a zero offset.
  a_wb_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && !writeback_valid |-> writeback_offset == '0)
    else $error("writeback offset set without writeback");

endmodule

bind lru_block_buffer_directory lrubd_checker u_lrubd_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .opcode           (opcode),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .hit              (hit),
  .fetch_valid      (fetch_valid),
  .writeback_valid  (writeback_valid),
  .writeback_offset (writeback_offset),
  .last             (last)
);
